>>> rtl/lssx_pkg.sv
// Shared types, constants and state codes of the lane segment selection block.
package lssx_pkg;

    localparam int C_COORD_BITS = 12;
    localparam int C_OPND_W     = C_COORD_BITS + 1;
    localparam int C_ACC_W      = 2 * C_COORD_BITS + 2;
    localparam int C_QUO_W      = C_ACC_W - 1;
    localparam int C_LEN_W      = 2 * C_COORD_BITS + 1;
    localparam int C_OUT_W      = 16;
    localparam int C_DIV_CNT_W  = $clog2(C_QUO_W + 1);

    localparam int C_SAT_MAX = 32767;
    localparam int C_SAT_MIN = -32768;

    // Reciprocal of three for the lane split, exact for operands below 2**17.
    localparam int C_DIV3_SH = 17;
    localparam int C_RECIP3  = (2 ** C_DIV3_SH + 2) / 3;

    localparam int C_WIDTH_RESET     = 640;
    localparam int C_HEIGHT_RESET    = 480;
    localparam int C_RIGHT_LIM_RESET = C_WIDTH_RESET - (2 * C_WIDTH_RESET) / 3;
    localparam int C_LEFT_LIM_RESET  = C_WIDTH_RESET - C_WIDTH_RESET / 3;

    localparam logic C_REG_WIDTH  = 1'b0;
    localparam logic C_REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [C_COORD_BITS-1:0] x_start;
        logic [C_COORD_BITS-1:0] y_start;
        logic [C_COORD_BITS-1:0] x_end;
        logic [C_COORD_BITS-1:0] y_end;
        logic                    has_segment;
        logic                    frame_end;
    } t_in_item;

    typedef struct packed {
        logic signed [C_OUT_W-1:0] right_top_x;
        logic signed [C_OUT_W-1:0] right_bottom_x;
        logic                      right_found;
        logic signed [C_OUT_W-1:0] left_top_x;
        logic signed [C_OUT_W-1:0] left_bottom_x;
        logic                      left_found;
    } t_out_item;

    typedef struct packed {
        logic [C_COORD_BITS-1:0] xa;
        logic [C_COORD_BITS-1:0] ya;
        logic [C_COORD_BITS-1:0] xb;
        logic [C_COORD_BITS-1:0] yb;
    } t_seg;

    typedef struct packed {
        logic                      en;
        logic                      clr;
        logic signed [C_OPND_W-1:0] a;
        logic signed [C_OPND_W-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic                    start;
        logic [C_QUO_W-1:0]      dividend;
        logic [C_COORD_BITS-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_DX,
        S_SQ_DY,
        S_OFFER,
        S_EXT,
        S_NUM_A,
        S_NUM_B,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

endpackage

>>> rtl/lssx_mac.sv
// Shared signed multiply-accumulate unit used for squared lengths and numerators.
module lssx_mac
    import lssx_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_op                    i_op,
    output logic signed [C_ACC_W-1:0]  o_acc
);

    logic signed [C_ACC_W-1:0] r_acc;
    logic signed [C_ACC_W-1:0] n_acc;
    logic signed [C_ACC_W-1:0] w_ea;
    logic signed [C_ACC_W-1:0] w_eb;

    always_comb begin
        w_ea  = C_ACC_W'($signed(i_op.a));
        w_eb  = C_ACC_W'($signed(i_op.b));
        n_acc = (i_op.clr ? '0 : r_acc) + C_ACC_W'(w_ea * w_eb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/lssx_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module lssx_div
    import lssx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [C_QUO_W-1:0]  o_quotient
);

    logic [C_DIV_CNT_W-1:0]   r_cnt;
    logic [C_QUO_W-1:0]       r_quo;
    logic [C_COORD_BITS-1:0]  r_rem;
    logic [C_COORD_BITS-1:0]  r_dvs;
    logic                     r_done;
    logic [C_COORD_BITS:0]    w_rem_sh;
    logic                     w_ge;
    logic [C_COORD_BITS:0]    w_rem_sub;
    logic [C_COORD_BITS-1:0]  n_rem;

    always_comb begin
        w_rem_sh  = {r_rem, r_quo[C_QUO_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_dvs});
        w_rem_sub = w_rem_sh - {1'b0, r_dvs};
        n_rem     = w_ge ? w_rem_sub[C_COORD_BITS-1:0] : w_rem_sh[C_COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dvs <= i_req.divisor;
                r_cnt <= C_DIV_CNT_W'(C_QUO_W);
            end else if (r_cnt != '0) begin
                r_quo <= {r_quo[C_QUO_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/lane_segment_select_extrapolate.sv
// Top level: lane segment selection by slope and length, with line extrapolation per frame.
//
//  Channel  Direction  Handshake                   Payload
//  input    in         i_in_valid / o_in_stall     i_in_data   (t_in_item)
//  output   out        o_out_valid / i_out_stall   o_out_data  (t_out_item)
//  config   in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// A segment request passes through acceptance, two passes through the shared
// multiply-accumulate unit (dx squared, then dy squared added) and the lane update.
// An empty request that does not end a frame is only accepted; the sequencer stays idle.
// On a frame-end request each kept lane is extended to the top and the bottom row;
// each extension waits on the restoring divider, which produces one quotient bit per
// cycle. The input is stalled whenever the sequencer is not idle. Reset (synchronous,
// active low) restores the register defaults and empties the per-frame state. A result
// waits in the output register while the output is stalled; further requests are taken
// meanwhile until the next frame end needs it.
module lane_segment_select_extrapolate
    import lssx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [C_COORD_BITS-1:0] i_cfg_data
);

    // Floor of n / 3 by multiplication with a reciprocal.
    function automatic logic [C_OPND_W-1:0] div3(input logic [C_OPND_W-1:0] n);
        logic [C_OPND_W+C_DIV3_SH-1:0] p;
        p = (C_OPND_W + C_DIV3_SH)'(n) * (C_OPND_W + C_DIV3_SH)'(C_RECIP3);
        return p[C_DIV3_SH +: C_OPND_W];
    endfunction

    t_state r_state;
    t_state n_state;

    // Configuration, with the lane split limits worked out at write time.
    logic [C_COORD_BITS-1:0] r_height;
    logic [C_COORD_BITS-1:0] r_right_lim;
    logic [C_COORD_BITS-1:0] r_left_lim;
    logic [C_OPND_W-1:0]     w_third;
    logic [C_OPND_W-1:0]     w_two_thirds;

    // Request being worked on and per-frame lane state.
    t_in_item                r_item;
    t_seg                    r_right_seg;
    t_seg                    r_left_seg;
    logic [C_LEN_W-1:0]      r_right_len;
    logic [C_LEN_W-1:0]      r_left_len;
    logic                    r_right_seen;
    logic                    r_left_seen;

    // Extension jobs: bit 1 picks the lane (left when set), bit 0 the row.
    logic [1:0]                r_job;
    logic signed [C_OUT_W-1:0] r_slot [4];

    logic                    r_out_valid;
    t_out_item               r_out_data;

    // Controls from the sequencer.
    logic                    w_accept;
    logic                    w_offer;
    logic                    w_job_clr;
    logic                    w_job_inc;
    logic                    w_slot_we;
    logic signed [C_OUT_W-1:0] w_slot_val;
    logic                    w_load_out;

    t_mac_op                 w_mac_op;
    logic signed [C_ACC_W-1:0] w_acc;
    t_div_req                w_div_req;
    logic                    w_div_done;
    logic [C_QUO_W-1:0]      w_quo;

    // Classification of the held request.
    logic signed [C_OPND_W-1:0] w_dx;
    logic signed [C_OPND_W-1:0] w_dy;
    logic [C_OPND_W-1:0]        w_adx_f;
    logic [C_OPND_W-1:0]        w_ady_f;
    logic                       w_keep;
    logic                       w_same_sign;
    logic                       w_to_right;
    logic [C_LEN_W-1:0]         w_len;

    // Extension of the selected lane.
    t_seg                       w_sel;
    logic                       w_sel_seen;
    logic signed [C_OPND_W-1:0] w_sel_dx;
    logic signed [C_OPND_W-1:0] w_sel_dy;
    logic [C_COORD_BITS-1:0]    w_row;
    logic signed [C_OPND_W-1:0] w_row_off;
    logic [C_ACC_W-1:0]         w_num_mag;
    logic [C_OPND_W-1:0]        w_dy_mag;
    logic                       w_neg;
    logic signed [C_ACC_W-1:0]  w_q;
    logic signed [C_ACC_W-1:0]  w_q_sat;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Classification: a segment is kept when it is steeper than one and not vertical.
    always_comb begin
        w_dx    = $signed({1'b0, r_item.x_end}) - $signed({1'b0, r_item.x_start});
        w_dy    = $signed({1'b0, r_item.y_end}) - $signed({1'b0, r_item.y_start});
        w_adx_f = w_dx[C_OPND_W-1] ? C_OPND_W'(-w_dx) : C_OPND_W'(w_dx);
        w_ady_f = w_dy[C_OPND_W-1] ? C_OPND_W'(-w_dy) : C_OPND_W'(w_dy);
        w_keep  = (w_dx != '0) &&
                  (w_ady_f[C_COORD_BITS-1:0] > w_adx_f[C_COORD_BITS-1:0]);
        w_same_sign = ((!w_dx[C_OPND_W-1]) && (w_dx != '0)) ==
                      ((!w_dy[C_OPND_W-1]) && (w_dy != '0));
        if (w_same_sign) begin
            w_to_right = (r_item.x_end > r_right_lim);
        end else begin
            w_to_right = !(r_item.x_start < r_left_lim);
        end
        w_len = w_acc[C_LEN_W-1:0];
    end

    // Numerator x1*dy + (row - y1)*dx and the signed, saturated quotient.
    always_comb begin
        w_sel      = r_job[1] ? r_left_seg : r_right_seg;
        w_sel_seen = r_job[1] ? r_left_seen : r_right_seen;
        w_sel_dx   = $signed({1'b0, w_sel.xb}) - $signed({1'b0, w_sel.xa});
        w_sel_dy   = $signed({1'b0, w_sel.yb}) - $signed({1'b0, w_sel.ya});
        w_row      = r_job[0] ? r_height : '0;
        w_row_off  = $signed({1'b0, w_row}) - $signed({1'b0, w_sel.ya});
        w_num_mag  = w_acc[C_ACC_W-1] ? C_ACC_W'(-w_acc) : C_ACC_W'(w_acc);
        w_dy_mag   = w_sel_dy[C_OPND_W-1] ? C_OPND_W'(-w_sel_dy) : C_OPND_W'(w_sel_dy);
        w_neg      = w_acc[C_ACC_W-1] ^ w_sel_dy[C_OPND_W-1];
        w_q        = w_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        if (w_q > $signed(C_ACC_W'(C_SAT_MAX))) begin
            w_q_sat = $signed(C_ACC_W'(C_SAT_MAX));
        end else if (w_q < $signed(C_ACC_W'(C_SAT_MIN))) begin
            w_q_sat = $signed(C_ACC_W'(C_SAT_MIN));
        end else begin
            w_q_sat = w_q;
        end
    end

    // Sequencer.
    always_comb begin
        n_state            = r_state;
        w_offer            = 1'b0;
        w_job_clr          = 1'b0;
        w_job_inc          = 1'b0;
        w_slot_we          = 1'b0;
        w_slot_val         = '0;
        w_load_out         = 1'b0;
        w_mac_op           = '0;
        w_div_req          = '0;
        w_div_req.dividend = w_num_mag[C_QUO_W-1:0];
        w_div_req.divisor  = w_dy_mag[C_COORD_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.has_segment) begin
                        n_state = S_SQ_DX;
                    end else if (i_in_data.frame_end) begin
                        w_job_clr = 1'b1;
                        n_state   = S_EXT;
                    end
                end
            end
            S_SQ_DX: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = 1'b1;
                w_mac_op.a   = w_dx;
                w_mac_op.b   = w_dx;
                n_state      = S_SQ_DY;
            end
            S_SQ_DY: begin
                w_mac_op.en = 1'b1;
                w_mac_op.a  = w_dy;
                w_mac_op.b  = w_dy;
                n_state     = S_OFFER;
            end
            S_OFFER: begin
                w_offer = 1'b1;
                if (r_item.frame_end) begin
                    w_job_clr = 1'b1;
                    n_state   = S_EXT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXT: begin
                if (w_sel_seen) begin
                    n_state = S_NUM_A;
                end else begin
                    // Lane not found: its x fields read zero.
                    w_slot_we = 1'b1;
                    if (r_job == 2'd3) begin
                        n_state = S_FINISH;
                    end else begin
                        w_job_inc = 1'b1;
                    end
                end
            end
            S_NUM_A: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = 1'b1;
                w_mac_op.a   = $signed({1'b0, w_sel.xa});
                w_mac_op.b   = w_sel_dy;
                n_state      = S_NUM_B;
            end
            S_NUM_B: begin
                w_mac_op.en = 1'b1;
                w_mac_op.a  = w_row_off;
                w_mac_op.b  = w_sel_dx;
                n_state     = S_DIV_GO;
            end
            S_DIV_GO: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    w_slot_we  = 1'b1;
                    w_slot_val = w_q_sat[C_OUT_W-1:0];
                    if (r_job == 2'd3) begin
                        n_state = S_FINISH;
                    end else begin
                        w_job_inc = 1'b1;
                        n_state   = S_EXT;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; the split limits are W - floor(2W/3) and W - floor(W/3).
    always_comb begin
        w_third      = div3({1'b0, i_cfg_data});
        w_two_thirds = div3({i_cfg_data, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= C_COORD_BITS'(C_HEIGHT_RESET);
            r_right_lim <= C_COORD_BITS'(C_RIGHT_LIM_RESET);
            r_left_lim  <= C_COORD_BITS'(C_LEFT_LIM_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_WIDTH: begin
                    r_right_lim <= i_cfg_data - w_two_thirds[C_COORD_BITS-1:0];
                    r_left_lim  <= i_cfg_data - w_third[C_COORD_BITS-1:0];
                end
                C_REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Request capture, lane store and result slots.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_slot_we) begin
            r_slot[r_job] <= w_slot_val;
        end
        if (w_offer && w_keep) begin
            if (w_to_right && (w_len > r_right_len)) begin
                r_right_seg <= {r_item.x_start, r_item.y_start, r_item.x_end, r_item.y_end};
            end
            if (!w_to_right && (w_len > r_left_len)) begin
                r_left_seg <= {r_item.x_start, r_item.y_start, r_item.x_end, r_item.y_end};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_len  <= '0;
            r_left_len   <= '0;
            r_right_seen <= 1'b0;
            r_left_seen  <= 1'b0;
            r_job        <= '0;
        end else begin
            if (w_job_clr) begin
                r_job <= '0;
            end else if (w_job_inc) begin
                r_job <= r_job + 2'd1;
            end
            if (w_load_out) begin
                // The frame is complete: empty the lane state for the next one.
                r_right_len  <= '0;
                r_left_len   <= '0;
                r_right_seen <= 1'b0;
                r_left_seen  <= 1'b0;
            end else if (w_offer && w_keep) begin
                // A tie keeps the earlier segment, so only a strictly longer one wins.
                if (w_to_right && (w_len > r_right_len)) begin
                    r_right_len  <= w_len;
                    r_right_seen <= 1'b1;
                end
                if (!w_to_right && (w_len > r_left_len)) begin
                    r_left_len  <= w_len;
                    r_left_seen <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data.right_top_x    <= r_slot[0];
            r_out_data.right_bottom_x <= r_slot[1];
            r_out_data.right_found    <= r_right_seen;
            r_out_data.left_top_x     <= r_slot[2];
            r_out_data.left_bottom_x  <= r_slot[3];
            r_out_data.left_found     <= r_left_seen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lssx_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_mac_op),
        .o_acc   (w_acc)
    );

    lssx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

endmodule

>>> test/lssx_checker.sv
// Checker for the lane segment selector: predicts each frame result and compares it.
`timescale 1ns / 100ps

module lane_result_checker
    import lssx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  t_in_item                i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  t_out_item               i_out_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [C_COORD_BITS-1:0] i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    // Lane results still owed by the block, oldest first.
    t_out_item lane_result_q[$];

    longint width_reg;
    longint height_reg;

    t_seg   right_seg;
    longint right_len_sq;
    bit     right_seen;
    t_seg   left_seg;
    longint left_len_sq;
    bit     left_seen;

    int mismatch_total = 0;

    function automatic void clear_lanes();
        right_seg    = '0;
        left_seg     = '0;
        right_len_sq = 0;
        left_len_sq  = 0;
        right_seen   = 1'b0;
        left_seen    = 1'b0;
    endfunction

    function automatic logic signed [C_OUT_W-1:0] saturate16(longint v);
        if (v > C_SAT_MAX) begin
            return C_OUT_W'(C_SAT_MAX);
        end
        if (v < C_SAT_MIN) begin
            return C_OUT_W'(C_SAT_MIN);
        end
        return C_OUT_W'(v);
    endfunction

    // x of the line through the kept segment at the given row; the quotient
    // truncates toward zero, as the signed division of SystemVerilog does.
    function automatic logic signed [C_OUT_W-1:0] lane_x_at_row(t_seg s, longint row);
        longint dx;
        longint dy;
        longint num;
        dx  = longint'(s.xb) - longint'(s.xa);
        dy  = longint'(s.yb) - longint'(s.ya);
        num = longint'(s.xa) * dy + (row - longint'(s.ya)) * dx;
        return saturate16(num / dy);
    endfunction

    function automatic void classify_segment(t_in_item r);
        t_seg   s;
        longint dx;
        longint dy;
        longint adx;
        longint ady;
        longint len_sq;
        bit     to_right;
        s.xa = r.x_start;
        s.ya = r.y_start;
        s.xb = r.x_end;
        s.yb = r.y_end;
        dx  = longint'(s.xb) - longint'(s.xa);
        dy  = longint'(s.yb) - longint'(s.ya);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        // Vertical and shallow segments cannot be lane markings.
        if (dx == 0 || ady <= adx) begin
            return;
        end
        len_sq = dx * dx + dy * dy;
        if ((dx > 0) == (dy > 0)) begin
            to_right = longint'(s.xb) > (width_reg - (2 * width_reg) / 3);
        end else begin
            to_right = !(longint'(s.xa) < (width_reg - width_reg / 3));
        end
        // Strictly longer only, so that on a tie the earlier segment stays.
        if (to_right) begin
            if (len_sq > right_len_sq) begin
                right_seg    = s;
                right_len_sq = len_sq;
                right_seen   = 1'b1;
            end
        end else if (len_sq > left_len_sq) begin
            left_seg    = s;
            left_len_sq = len_sq;
            left_seen   = 1'b1;
        end
    endfunction

    function automatic void take_request(t_in_item r);
        t_out_item res;
        if (r.has_segment) begin
            classify_segment(r);
        end
        if (!r.frame_end) begin
            return;
        end
        res = '0;
        if (right_seen) begin
            res.right_top_x    = lane_x_at_row(right_seg, 0);
            res.right_bottom_x = lane_x_at_row(right_seg, height_reg);
            res.right_found    = 1'b1;
        end
        if (left_seen) begin
            res.left_top_x    = lane_x_at_row(left_seg, 0);
            res.left_bottom_x = lane_x_at_row(left_seg, height_reg);
            res.left_found    = 1'b1;
        end
        lane_result_q.insert(lane_result_q.size(), res);
        clear_lanes();
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (lane_result_q.size() == 0) begin
            $display("%0t: result %h arrived with no result expected", $time, got);
            mismatch_total++;
            return;
        end
        want = lane_result_q.pop_front();
        check_field("right_top_x", want.right_top_x, got.right_top_x);
        check_field("right_bottom_x", want.right_bottom_x, got.right_bottom_x);
        check_field("right_found", want.right_found, got.right_found);
        check_field("left_top_x", want.left_top_x, got.left_top_x);
        check_field("left_bottom_x", want.left_bottom_x, got.left_bottom_x);
        check_field("left_found", want.left_found, got.left_found);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = C_WIDTH_RESET;
            height_reg = C_HEIGHT_RESET;
            clear_lanes();
            lane_result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == C_REG_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            // The request side is handled first so that a frame end taken at
            // the same edge as an older result cannot upset the ordering.
            if (i_in_valid && !i_in_stall) begin
                take_request(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= lane_result_q.size();
    end

endmodule

>>> test/testbench.sv
// Top of the lane segment selector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench
    import lssx_pkg::*;
();

    // The number of random requests per configuration phase; eight phases plus
    // the directed frames come to roughly nine hundred and fifty requests.
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int COORD_MAX     = (1 << C_COORD_BITS) - 1;
    // The idle limit is taken well above the sum of the longest frame end, the long
    // receiver hold-off and the longest sender gap.
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 5000;
    // A segment request keeps the block busy through the squaring and offer states after acceptance.
    localparam int SETTLE_CYCLES = 16;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_in_item                i_in_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_out_item               o_out_data;
    logic                    i_cfg_we;
    logic                    i_cfg_idx;
    logic [C_COORD_BITS-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // Shared between the request driver and the receiver: calm switches all
    // idling off for a stretch, hold_off_req asks the receiver for one long stall.
    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;

    // Current image width, kept here only to aim segments at the lane split.
    int cur_width = C_WIDTH_RESET;
    int last_adx  = 1;
    int last_ady  = 2;

    always #5 i_clk = ~i_clk;

    lane_segment_select_extrapolate DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    lane_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_request(int xa, int ya, int xb, int yb, bit has, bit fe);
        t_in_item r;
        r.x_start     = C_COORD_BITS'(xa);
        r.y_start     = C_COORD_BITS'(ya);
        r.x_end       = C_COORD_BITS'(xb);
        r.y_end       = C_COORD_BITS'(yb);
        r.has_segment = has;
        r.frame_end   = fe;
        return r;
    endfunction

    function automatic t_in_item random_coords(bit has, bit fe);
        return make_request($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            has, fe);
    endfunction

    // A steep segment of the given extents, placed and oriented at random.
    // Now and then it is moved so that the endpoint that decides its lane sits
    // on the split of the current width or just beside it.
    function automatic t_in_item steep_segment(int adx, int ady, bit fe);
        int xa;
        int ya;
        int xb;
        int yb;
        int t;
        int shift;
        xa = $urandom_range(0, COORD_MAX - adx);
        xb = xa + adx;
        ya = $urandom_range(0, COORD_MAX - ady);
        yb = ya + ady;
        if ($urandom_range(0, 1)) begin
            t  = xa;
            xa = xb;
            xb = t;
        end
        if ($urandom_range(0, 1)) begin
            t  = ya;
            ya = yb;
            yb = t;
        end
        if ($urandom_range(0, 9) == 0) begin
            if ((xb > xa) == (yb > ya)) begin
                shift = cur_width - (2 * cur_width) / 3 + $urandom_range(0, 1) - xb;
            end else begin
                shift = cur_width - cur_width / 3 - $urandom_range(0, 1) - xa;
            end
            if (xa + shift >= 0 && xa + shift <= COORD_MAX &&
                xb + shift >= 0 && xb + shift <= COORD_MAX) begin
                xa += shift;
                xb += shift;
            end
        end
        return make_request(xa, ya, xb, yb, 1'b1, fe);
    endfunction

    // A lane candidate: usually fresh extents, sometimes those of the previous
    // candidate again, which gives an equal squared length on another line.
    function automatic t_in_item lane_candidate(bit fe);
        if ($urandom_range(0, 9) != 0) begin
            last_ady = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40)
                                                   : $urandom_range(2, COORD_MAX);
            last_adx = $urandom_range(1, last_ady - 1);
        end
        return steep_segment(last_adx, last_ady, fe);
    endfunction

    // Offers one request and returns at the edge that accepts it. Valid stays
    // high into the next request when that one comes without a gap.
    task automatic send_request(t_in_item req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Lets every owed result come out and the block settle, so that it is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(int width, int height);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= C_REG_WIDTH;
        i_cfg_data <= C_COORD_BITS'(width);
        @(posedge i_clk);
        i_cfg_idx  <= C_REG_HEIGHT;
        i_cfg_data <= C_COORD_BITS'(height);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_width  = width;
    endtask

    // Frames of a few requests each. Most of them are steep lane candidates;
    // the rest are arbitrary segments, which are mostly dropped, and empty
    // markers. The frame end carries a candidate, an arbitrary segment or
    // nothing. Empty markers that do not end a frame are not counted.
    task automatic random_frames(int count, bit phase_calm);
        int sent;
        int n_seg;
        int r;
        sent = 0;
        while (sent < count) begin
            calm  = phase_calm || ($urandom_range(0, 9) == 0);
            n_seg = $urandom_range(0, 6);
            repeat (n_seg) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    send_request(lane_candidate(1'b0));
                    sent++;
                end else if (r < 90) begin
                    send_request(random_coords(1'b1, 1'b0));
                    sent++;
                end else begin
                    send_request(random_coords(1'b0, 1'b0));
                end
            end
            r = $urandom_range(0, 9);
            if (r < 5) begin
                send_request(lane_candidate(1'b1));
            end else if (r < 7) begin
                send_request(random_coords(1'b1, 1'b1));
            end else begin
                send_request(random_coords(1'b0, 1'b1));
            end
            sent++;
        end
    endtask

    // Receiver: random stalls of mixed length, and on request one long
    // hold-off counted here, during which the output register stays full and
    // the next frame end backs up into the request side.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run when nothing has been accepted on either side for
    // too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int width;
        int height;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= C_REG_WIDTH;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset configuration, whose lane split lies
        // at C_RIGHT_LIM_RESET for rising and C_LEFT_LIM_RESET for falling lines.
        // A frame with nothing in it reports both lanes as not found.
        send_request(make_request(0, 0, 0, 0, 1'b0, 1'b1));
        // A vertical, a diagonal and a shallow segment are all dropped.
        send_request(make_request(100, 0, 100, 400, 1'b1, 1'b0));
        send_request(make_request(100, 100, 300, 300, 1'b1, 1'b0));
        send_request(make_request(0, 0, 400, 100, 1'b1, 1'b0));
        send_request(make_request(0, 0, 0, 0, 1'b0, 1'b1));
        // Rising lines ending on the split go left, one past it go right; the
        // second one also ends the frame.
        send_request(make_request(C_RIGHT_LIM_RESET - 10, 0, C_RIGHT_LIM_RESET, 200,
                                  1'b1, 1'b0));
        send_request(make_request(C_RIGHT_LIM_RESET - 9, 300, C_RIGHT_LIM_RESET + 1, 500,
                                  1'b1, 1'b1));
        // Falling lines starting just before the split go left, on it go right;
        // an empty marker with all coordinate bits set sits between them.
        send_request(make_request(C_LEFT_LIM_RESET - 1, 0, C_LEFT_LIM_RESET - 21, 300,
                                  1'b1, 1'b0));
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0));
        send_request(make_request(C_LEFT_LIM_RESET, 100, C_LEFT_LIM_RESET - 30, 400,
                                  1'b1, 1'b0));
        send_request(make_request(0, 0, 0, 0, 1'b0, 1'b1));
        // Equal lengths keep the first segment, a shorter one changes nothing,
        // and full-height segments follow, the last of them with the frame end.
        send_request(make_request(400, 0, 410, 100, 1'b1, 1'b0));
        send_request(make_request(500, 0, 510, 100, 1'b1, 1'b0));
        send_request(make_request(600, 0, 605, 50, 1'b1, 1'b0));
        send_request(make_request(0, 0, 1, COORD_MAX, 1'b1, 1'b0));
        send_request(make_request(0, COORD_MAX, 1, 0, 1'b1, 1'b0));
        send_request(make_request(COORD_MAX, 0, COORD_MAX - 1, COORD_MAX, 1'b1, 1'b1));
        // Starting at the far corner, with both coordinates falling.
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MAX - 1, 0, 1'b1, 1'b0));
        send_request(make_request(0, 0, 0, 0, 1'b0, 1'b1));
        // The coordinates of an empty frame end with all coordinate bits set are ignored.
        send_request(make_request(10, COORD_MAX, 0, 0, 1'b1, 1'b0));
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1));

        // Random phases. The first keeps the reset configuration, the others
        // write both registers while the block is idle, extremes included.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: begin
                        width  = COORD_MAX;
                        height = COORD_MAX;
                    end
                    2: begin
                        width  = 1;
                        height = 1;
                    end
                    3: begin
                        width  = 0;
                        height = 0;
                    end
                    4: begin
                        width  = C_WIDTH_RESET;
                        height = 1;
                    end
                    5: begin
                        width  = 1;
                        height = COORD_MAX;
                    end
                    default: begin
                        width  = $urandom_range(1, COORD_MAX);
                        height = $urandom_range(1, COORD_MAX);
                    end
                endcase
                write_config(width, height);
            end
            // One long receiver hold-off while requests keep coming.
            if (phase == 1) begin
                hold_off_req = 1'b1;
            end
            random_frames(ITEMS_PER_PHASE, phase == 4);
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
